FILE: rtl/bbd_pkg.sv
// Package for the binary block deframer: phase and status codes, result struct,
// framing constants and the byte-wide CRC-16 CCITT update. No dependencies.
package bbd_pkg;

    localparam logic [7:0]  SYNC_A         = 8'h24;
    localparam logic [7:0]  SYNC_B         = 8'h40;
    localparam logic [15:0] CRC_POLY       = 16'h1021;
    localparam logic [15:0] MIN_LEN        = 16'd14;
    localparam logic [15:0] HDR_LEN        = 16'd8;
    localparam logic [31:0] TOW_BAD        = 32'hffff_ffff;
    localparam logic [15:0] WEEK_BAD       = 16'hffff;
    localparam logic [15:0] MAX_LEN_RESET  = 16'd16384;

    // Byte offsets of the header fields
    localparam logic [15:0] OFF_CRC_LO  = 16'd2;
    localparam logic [15:0] OFF_CRC_HI  = 16'd3;
    localparam logic [15:0] OFF_ID_LO   = 16'd4;
    localparam logic [15:0] OFF_ID_HI   = 16'd5;
    localparam logic [15:0] OFF_LEN_LO  = 16'd6;
    localparam logic [15:0] OFF_LEN_HI  = 16'd7;
    localparam logic [15:0] OFF_TOW_0   = 16'd8;
    localparam logic [15:0] OFF_TOW_1   = 16'd9;
    localparam logic [15:0] OFF_TOW_2   = 16'd10;
    localparam logic [15:0] OFF_TOW_3   = 16'd11;
    localparam logic [15:0] OFF_WEEK_LO = 16'd12;
    localparam logic [15:0] OFF_WEEK_HI = 16'd13;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_SYNC = 2'd1,
        PH_BODY = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_LONG  = 3'd1,
        ST_CRC_ERR   = 3'd2,
        ST_TOO_SHORT = 3'd3,
        ST_TIME_BAD  = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] byte_offset;
        logic        last;
        t_status     status;
        logic [12:0] block_type;
        logic [2:0]  block_revision;
        logic [31:0] tow_ms;
        logic [15:0] week_number;
    } t_result;

    // CRC-16 CCITT, MSB first, one byte per call
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/binary_block_deframer_crc16.sv
// Top level of the binary block deframer with CRC-16 check.
// Depends on bbd_pkg, bbd_parser and bbd_out_reg.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------
//  input    | i_in_valid / o_in_ready    | i_rx_byte
//  output   | o_out_valid / i_out_ready  | o_data_byte .. o_week_number
//  config   | i_cfg_wr_en                | i_cfg_wr_data (max block length)
//
// One byte per cycle while o_in_ready is high: the parser resolves each byte
// combinationally through a byte-wide CRC update and header compare, and the
// result is loaded into the output register at the edge that accepts the byte.
// Reset is synchronous, active low; the length limit returns to 16384.
// A stalled output holds the input only while the result register is full.
module binary_block_deframer_crc16 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_data_byte,
    output logic [15:0] o_byte_offset,
    output logic        o_last,
    output logic [2:0]  o_status,
    output logic [12:0] o_block_type,
    output logic [2:0]  o_block_revision,
    output logic [31:0] o_tow_ms,
    output logic [15:0] o_week_number
);
    import bbd_pkg::*;

    logic    w_accept;
    logic    w_res_valid;
    logic    w_free;
    t_result w_res;
    t_result w_out;

    assign o_in_ready = w_free;
    assign w_accept   = i_in_valid && w_free;

    // Parse the byte stream
    bbd_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (w_accept),
        .i_rx_byte     (i_rx_byte),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    // Register the result transaction
    bbd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_accept && w_res_valid),
        .i_res       (w_res),
        .i_out_ready (i_out_ready),
        .o_free      (w_free),
        .o_out_valid (o_out_valid),
        .o_res       (w_out)
    );

    assign o_data_byte      = w_out.data_byte;
    assign o_byte_offset    = w_out.byte_offset;
    assign o_last           = w_out.last;
    assign o_status         = w_out.status;
    assign o_block_type     = w_out.block_type;
    assign o_block_revision = w_out.block_revision;
    assign o_tow_ms         = w_out.tow_ms;
    assign o_week_number    = w_out.week_number;

endmodule

FILE: rtl/bbd_parser.sv
// Frame parser: sync hunt, header capture, CRC and end-of-block status.
// Depends on bbd_pkg; produces one t_result per accepted body byte after the CRC field.
module bbd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [15:0]       i_cfg_wr_data,
    input  logic              i_accept,
    input  logic [7:0]        i_rx_byte,
    output logic              o_res_valid,
    output bbd_pkg::t_result  o_res
);
    import bbd_pkg::*;

    t_phase      r_phase,        n_phase;
    logic [15:0] r_byte_count,   n_byte_count;
    logic [15:0] r_crc_running,  n_crc_running;
    logic [15:0] r_crc_received, n_crc_received;
    logic [15:0] r_block_id,     n_block_id;
    logic [15:0] r_block_length, n_block_length;
    logic [31:0] r_tow_field,    n_tow_field;
    logic [15:0] r_week_field,   n_week_field;
    logic [15:0] r_max_len;

    logic [15:0] w_off;
    logic [16:0] w_off_p1;
    logic        w_last;
    t_status     w_status;
    t_status     w_final;

    assign w_off    = r_byte_count;
    assign w_off_p1 = {1'b0, r_byte_count} + 17'd1;

    // End-of-block checks on the field values including this byte
    always_comb begin
        if (n_crc_running != r_crc_received) begin
            w_final = ST_CRC_ERR;
        end else if (n_block_length < MIN_LEN) begin
            w_final = ST_TOO_SHORT;
        end else if (n_tow_field == TOW_BAD || n_week_field == WEEK_BAD) begin
            w_final = ST_TIME_BAD;
        end else begin
            w_final = ST_OK;
        end
    end

    // Next state and result for the incoming byte
    always_comb begin
        n_phase        = r_phase;
        n_byte_count   = r_byte_count;
        n_crc_running  = r_crc_running;
        n_crc_received = r_crc_received;
        n_block_id     = r_block_id;
        n_block_length = r_block_length;
        n_tow_field    = r_tow_field;
        n_week_field   = r_week_field;
        o_res_valid    = 1'b0;
        w_last         = 1'b0;
        w_status       = ST_OK;
        case (r_phase)
            PH_HUNT: begin
                if (i_rx_byte == SYNC_A) begin
                    n_phase = PH_SYNC;
                end
            end
            PH_SYNC: begin
                if (i_rx_byte == SYNC_B) begin
                    n_phase        = PH_BODY;
                    n_byte_count   = OFF_CRC_LO;
                    n_crc_running  = '0;
                    n_crc_received = '0;
                    n_block_id     = '0;
                    n_block_length = '0;
                    n_tow_field    = '0;
                    n_week_field   = '0;
                end else if (i_rx_byte != SYNC_A) begin
                    n_phase = PH_HUNT;
                end
            end
            PH_BODY: begin
                n_byte_count = w_off_p1[15:0];
                if (w_off == OFF_CRC_LO) begin
                    n_crc_received = r_crc_received | {8'h00, i_rx_byte};
                end else if (w_off == OFF_CRC_HI) begin
                    n_crc_received = r_crc_received | {i_rx_byte, 8'h00};
                end else begin
                    o_res_valid   = 1'b1;
                    n_crc_running = crc_update(r_crc_running, i_rx_byte);
                    case (w_off)
                        OFF_ID_LO:   n_block_id     = r_block_id | {8'h00, i_rx_byte};
                        OFF_ID_HI:   n_block_id     = r_block_id | {i_rx_byte, 8'h00};
                        OFF_LEN_LO:  n_block_length = r_block_length | {8'h00, i_rx_byte};
                        OFF_LEN_HI:  n_block_length = r_block_length | {i_rx_byte, 8'h00};
                        OFF_TOW_0:   n_tow_field    = r_tow_field | {24'h0, i_rx_byte};
                        OFF_TOW_1:   n_tow_field    = r_tow_field | {16'h0, i_rx_byte, 8'h0};
                        OFF_TOW_2:   n_tow_field    = r_tow_field | {8'h0, i_rx_byte, 16'h0};
                        OFF_TOW_3:   n_tow_field    = r_tow_field | {i_rx_byte, 24'h0};
                        OFF_WEEK_LO: n_week_field   = r_week_field | {8'h00, i_rx_byte};
                        OFF_WEEK_HI: n_week_field   = r_week_field | {i_rx_byte, 8'h00};
                        default: ;
                    endcase
                    // Length known at the last header byte
                    if (w_off == OFF_LEN_HI) begin
                        if (n_block_length > r_max_len) begin
                            w_last   = 1'b1;
                            w_status = ST_TOO_LONG;
                        end else if (n_block_length < HDR_LEN) begin
                            w_last   = 1'b1;
                            w_status = ST_TOO_SHORT;
                        end else if (n_block_length == HDR_LEN) begin
                            w_last   = 1'b1;
                            w_status = w_final;
                        end
                    end else if (w_off > OFF_LEN_HI && w_off_p1 >= {1'b0, n_block_length}) begin
                        w_last   = 1'b1;
                        w_status = w_final;
                    end
                    if (w_last) begin
                        n_phase = PH_HUNT;
                    end
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
    end

    // Assemble the result fields
    always_comb begin
        o_res.data_byte      = i_rx_byte;
        o_res.byte_offset    = w_off;
        o_res.last           = w_last;
        o_res.status         = w_last ? w_status : ST_OK;
        o_res.block_type     = n_block_id[12:0];
        o_res.block_revision = n_block_id[15:13];
        o_res.tow_ms         = w_last ? n_tow_field : 32'h0;
        o_res.week_number    = w_last ? n_week_field : 16'h0;
    end

    // Advance state on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_HUNT;
            r_byte_count   <= '0;
            r_crc_running  <= '0;
            r_crc_received <= '0;
            r_block_id     <= '0;
            r_block_length <= '0;
            r_tow_field    <= '0;
            r_week_field   <= '0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_byte_count   <= n_byte_count;
            r_crc_running  <= n_crc_running;
            r_crc_received <= n_crc_received;
            r_block_id     <= n_block_id;
            r_block_length <= n_block_length;
            r_tow_field    <= n_tow_field;
            r_week_field   <= n_week_field;
        end
    end

    // Hold the length limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_len <= i_cfg_wr_data;
        end
    end

endmodule

FILE: rtl/bbd_out_reg.sv
// Result register: holds one finished result until the consumer takes it.
// Depends on bbd_pkg for the t_result struct.
module bbd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  bbd_pkg::t_result  i_res,
    input  logic              i_out_ready,
    output logic              o_free,
    output logic              o_out_valid,
    output bbd_pkg::t_result  o_res
);
    import bbd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Free when empty or being drained this cycle
    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_res       = r_res;

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule
